[src/salc_pkg.sv]
// Shared types and constants for the set-associative LRU tag store.
// No dependencies; imported by every module of the block except salc_ram.
package salc_pkg;

  localparam int ADDR_IN_W  = 32;
  localparam int WAY_OUT_W  = 3;
  localparam int COUNT_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int OFFSET_W   = 4;
  localparam int INDEX_W    = 4;
  localparam int ASSOC_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ASSOC  = 2'd2;

  localparam logic [OFFSET_W-1:0] OFFSET_RST = 4'd6;
  localparam logic [INDEX_W-1:0]  INDEX_RST  = 4'd8;
  localparam logic [ASSOC_W-1:0]  ASSOC_RST  = 2'd3;

  typedef struct packed {
    logic lookup;
    logic update;
    logic clear;
  } salc_cmd_t;

  typedef struct packed {
    logic clear_last;
  } salc_sts_t;

endpackage

[src/salc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/salc_ctrl.sv]
// Controller: clearing pass after reset, lookup and update sequencing, output valid.
// Depends on salc_pkg.
module salc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output salc_pkg::salc_cmd_t cmd,
  input  salc_pkg::salc_sts_t sts
);
  import salc_pkg::*;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.lookup = 1'b1;
          state_nxt  = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!out_valid_r || out_ready) begin
          cmd.update = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.update) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[src/salc_dpath.sv]
// Datapath: config registers, address split, per-way tag RAMs, hit/victim/rank logic,
// miss counter and result word registers. Depends on salc_pkg and salc_ram.
module salc_dpath #(
  parameter int ADDR_BITS      = 32,
  parameter int MAX_INDEX_BITS = 8,
  parameter int MAX_ASSOC_BITS = 3
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [salc_pkg::ADDR_IN_W-1:0]      in_address,
  input  salc_pkg::salc_cmd_t                 cmd,
  output salc_pkg::salc_sts_t                 sts,
  output logic                                out_hit,
  output logic [salc_pkg::WAY_OUT_W-1:0]      out_way_used,
  output logic [salc_pkg::COUNT_W-1:0]        out_miss_total
);
  import salc_pkg::*;

  localparam int NUM_SETS = 1 << MAX_INDEX_BITS;
  localparam int NW       = 1 << MAX_ASSOC_BITS;
  localparam int SW       = (MAX_INDEX_BITS > 0) ? MAX_INDEX_BITS : 1;
  localparam int AW       = (MAX_ASSOC_BITS > 0) ? MAX_ASSOC_BITS : 1;
  localparam int RW       = AW;
  localparam int WW       = 1 + RW + ADDR_BITS;
  localparam logic [RW-1:0]      RANK_MAX = RW'(NW - 1);
  localparam logic [SW-1:0]      SET_LAST = SW'(NUM_SETS - 1);
  localparam logic [INDEX_W-1:0] IB_LIM   = INDEX_W'(MAX_INDEX_BITS);
  localparam logic [ASSOC_W-1:0] AB_LIM   = (MAX_ASSOC_BITS > 3) ? 2'd3 :
                                            ASSOC_W'(MAX_ASSOC_BITS);

  logic [OFFSET_W-1:0]  offset_r;
  logic [INDEX_W-1:0]   index_r;
  logic [ASSOC_W-1:0]   assoc_r;
  logic [SW-1:0]        clr_cnt_r;
  logic [ADDR_BITS-1:0] tag_r;
  logic [SW-1:0]        set_r;
  logic [NW-1:0]        act_r;
  logic [COUNT_W-1:0]   miss_r, miss_nxt;
  logic                 out_hit_r;
  logic [WAY_OUT_W-1:0] out_way_r;

  // address split
  logic [ADDR_BITS-1:0] addr_ext;
  logic [INDEX_W-1:0]   ib;
  logic [ASSOC_W-1:0]   ab;
  logic [SW-1:0]        idx_keep;
  logic [SW-1:0]        set_comb;
  logic [ADDR_BITS-1:0] tag_comb;
  logic [NW-1:0]        act_comb;

  always_comb begin
    addr_ext = ADDR_BITS'(in_address);
    ib = (index_r > IB_LIM) ? IB_LIM : index_r;
    ab = (assoc_r > AB_LIM) ? AB_LIM : assoc_r;
    for (int i = 0; i < SW; i++) begin
      idx_keep[i] = (INDEX_W'(i) < ib);
    end
    set_comb = SW'(addr_ext >> offset_r) & idx_keep;
    tag_comb = addr_ext >> ({1'b0, offset_r} + {1'b0, ib});
    for (int w = 0; w < NW; w++) begin
      act_comb[w] = ((AW'(w) >> ab) == '0);
    end
  end

  // way RAMs: {valid, rank, tag}
  logic [WW-1:0]        rd_word [NW];
  logic [WW-1:0]        wr_word [NW];
  logic                 v_w     [NW];
  logic [RW-1:0]        rank_w  [NW];
  logic [ADDR_BITS-1:0] tag_w   [NW];
  logic                 ram_we;
  logic [SW-1:0]        ram_waddr;

  assign ram_we    = cmd.clear | cmd.update;
  assign ram_waddr = cmd.clear ? clr_cnt_r : set_r;

  for (genvar g = 0; g < NW; g++) begin : g_way
    assign v_w[g]    = rd_word[g][WW-1];
    assign rank_w[g] = rd_word[g][ADDR_BITS +: RW];
    assign tag_w[g]  = rd_word[g][ADDR_BITS-1:0];

    salc_ram #(
      .WIDTH (WW),
      .DEPTH (NUM_SETS),
      .AW    (SW)
    ) u_ram (
      .clk     (clk),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (wr_word[g]),
      .rd_en   (cmd.lookup),
      .rd_addr (set_comb),
      .rd_data (rd_word[g])
    );
  end

  // hit, victim and rank update
  logic          hit_found, free_found, sel_valid;
  logic [AW-1:0] hit_way, free_way, vict_way, sel_way;
  logic [RW-1:0] worst, sel_rank, rank_new;

  always_comb begin
    hit_found  = 1'b0;
    free_found = 1'b0;
    hit_way    = '0;
    free_way   = '0;
    vict_way   = '0;
    worst      = '0;
    rank_new   = '0;
    for (int w = 0; w < NW; w++) begin
      if (act_r[w] && v_w[w] && tag_w[w] == tag_r && !hit_found) begin
        hit_found = 1'b1;
        hit_way   = AW'(w);
      end
      if (act_r[w] && !v_w[w] && !free_found) begin
        free_found = 1'b1;
        free_way   = AW'(w);
      end
      if (act_r[w] && (w == 0 || rank_w[w] > worst)) begin
        worst    = rank_w[w];
        vict_way = AW'(w);
      end
    end
    sel_way   = hit_found ? hit_way : (free_found ? free_way : vict_way);
    sel_valid = v_w[sel_way];
    sel_rank  = rank_w[sel_way];
    for (int w = 0; w < NW; w++) begin
      if (cmd.clear) begin
        wr_word[w] = '0;
      end else if (AW'(w) == sel_way) begin
        wr_word[w] = {1'b1, {RW{1'b0}}, tag_r};
      end else begin
        rank_new = rank_w[w];
        if (act_r[w] && v_w[w] && (!sel_valid || rank_w[w] < sel_rank) &&
            rank_w[w] != RANK_MAX) begin
          rank_new = rank_w[w] + 1'b1;
        end
        wr_word[w] = {v_w[w], rank_new, tag_w[w]};
      end
    end
    miss_nxt = miss_r;
    if (!hit_found && miss_r != '1) begin
      miss_nxt = miss_r + 1'b1;
    end
  end

  assign sts.clear_last = (clr_cnt_r == SET_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r  <= OFFSET_RST;
      index_r   <= INDEX_RST;
      assoc_r   <= ASSOC_RST;
      clr_cnt_r <= '0;
      miss_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OFFSET: offset_r <= cfg_data[OFFSET_W-1:0];
          REG_INDEX:  index_r  <= cfg_data[INDEX_W-1:0];
          REG_ASSOC:  assoc_r  <= cfg_data[ASSOC_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clear) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.update) begin
        miss_r <= miss_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      tag_r <= tag_comb;
      set_r <= set_comb;
      act_r <= act_comb;
    end
    if (cmd.update) begin
      out_hit_r <= hit_found;
      out_way_r <= WAY_OUT_W'(sel_way);
    end
  end

  assign out_hit        = out_hit_r;
  assign out_way_used   = out_way_r;
  assign out_miss_total = miss_r;

endmodule

[src/set_assoc_lru_cache_tags.sv]
// Set-associative tag store with true LRU replacement; each input word is a byte address
// and each output word reports hit, the way hit or filled, and the saturating miss count.
// Each item is handled as a lookup step, which reads all ways of the set from the per-way
// RAMs, then an update step, which compares tags, picks the way, and writes back tags and
// ranks (read-modify-write of the set). A new address is taken only between items; a
// result held by out_ready stalls the write-back. After reset a clearing pass over all
// 2**MAX_INDEX_BITS sets zeroes the tag RAMs while in_ready stays low; configuration
// writes are taken anytime and leave stored lines in place.
module set_assoc_lru_cache_tags #(
  parameter int ADDR_BITS      = 32,
  parameter int MAX_INDEX_BITS = 8,
  parameter int MAX_ASSOC_BITS = 3
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [salc_pkg::ADDR_IN_W-1:0]  in_address,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_hit,
  output logic [salc_pkg::WAY_OUT_W-1:0]  out_way_used,
  output logic [salc_pkg::COUNT_W-1:0]    out_miss_total
);
  import salc_pkg::*;

  salc_cmd_t cmd;
  salc_sts_t sts;

  assign cfg_ready = 1'b1;

  salc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  salc_dpath #(
    .ADDR_BITS      (ADDR_BITS),
    .MAX_INDEX_BITS (MAX_INDEX_BITS),
    .MAX_ASSOC_BITS (MAX_ASSOC_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_address     (in_address),
    .cmd            (cmd),
    .sts            (sts),
    .out_hit        (out_hit),
    .out_way_used   (out_way_used),
    .out_miss_total (out_miss_total)
  );

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
    else $error("more than one datapath command");

  a_lookup_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (!in_ready && !cmd.clear))
    else $error("new word taken during set update");

  a_update_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  a_update_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> out_valid)
    else $error("result not presented after update");

endmodule

[tb/set_assoc_lru_cache_tags_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the LRU tag store: tracks config writes, predicts each lookup
// and compares every result word. Depends on salc_pkg only.
module set_assoc_lru_cache_tags_checker #(
  parameter int MAX_INDEX_BITS = 8,
  parameter int MAX_ASSOC_BITS = 3
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [salc_pkg::ADDR_IN_W-1:0]  in_address,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            out_hit,
  input  logic [salc_pkg::WAY_OUT_W-1:0]  out_way_used,
  input  logic [salc_pkg::COUNT_W-1:0]    out_miss_total,
  output int                              mismatches,
  output int                              lookups_pending
);
  import salc_pkg::*;

  localparam int SETS = 1 << MAX_INDEX_BITS;
  localparam int WAYS = 1 << MAX_ASSOC_BITS;

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic [COUNT_W-1:0]   misses;
  } lookup_t;

  logic [OFFSET_W-1:0]  offset_sel;
  logic [INDEX_W-1:0]   index_sel;
  logic [ASSOC_W-1:0]   assoc_sel;
  bit                   line_ok    [SETS][WAYS];
  logic [ADDR_IN_W-1:0] line_label [SETS][WAYS];
  logic [WAY_OUT_W-1:0] line_age   [SETS][WAYS];
  logic [COUNT_W-1:0]   miss_count;
  lookup_t              expected_lookups[$];
  int                   error_total;

  function automatic lookup_t predict_lookup(input logic [ADDR_IN_W-1:0] addr);
    int      ib;
    int      nways;
    int      set_no;
    int      pick;
    int      age_limit;
    logic    hit_now;
    logic    found;
    logic [63:0] wide;
    logic [63:0] tag_wide;
    lookup_t res;
    ib = (index_sel > MAX_INDEX_BITS) ? MAX_INDEX_BITS : index_sel;
    nways = 1 << ((assoc_sel > MAX_ASSOC_BITS) ? MAX_ASSOC_BITS : assoc_sel);
    wide = {32'd0, addr};
    set_no = int'((wide >> offset_sel) & ((64'd1 << ib) - 64'd1));
    tag_wide = wide >> (offset_sel + ib);
    hit_now = 1'b0;
    pick = 0;
    for (int w = 0; w < nways; w++) begin
      if (!hit_now && line_ok[set_no][w] && line_label[set_no][w] == tag_wide[ADDR_IN_W-1:0]) begin
        hit_now = 1'b1;
        pick = w;
      end
    end
    if (!hit_now) begin
      if (miss_count != '1) miss_count = miss_count + 1'b1;
      found = 1'b0;
      for (int w = 0; w < nways; w++) begin
        if (!found && !line_ok[set_no][w]) begin
          found = 1'b1;
          pick = w;
        end
      end
      if (!found) begin
        for (int w = 0; w < nways; w++) begin
          if (w == 0 || line_age[set_no][w] > line_age[set_no][pick]) pick = w;
        end
      end
    end
    // promote to most recent; only younger valid lines age
    age_limit = line_ok[set_no][pick] ? line_age[set_no][pick] : WAYS;
    for (int w = 0; w < nways; w++) begin
      if (w != pick && line_ok[set_no][w] && line_age[set_no][w] < age_limit &&
          line_age[set_no][w] < WAYS - 1)
        line_age[set_no][w] = line_age[set_no][w] + 1'b1;
    end
    line_age[set_no][pick] = '0;
    line_ok[set_no][pick] = 1'b1;
    line_label[set_no][pick] = tag_wide[ADDR_IN_W-1:0];
    res.hit = hit_now;
    res.way = WAY_OUT_W'(pick);
    res.misses = miss_count;
    return res;
  endfunction

  always @(posedge clk) begin
    lookup_t want;
    if (!rst_n) begin
      offset_sel = OFFSET_RST;
      index_sel = INDEX_RST;
      assoc_sel = ASSOC_RST;
      miss_count = '0;
      for (int s = 0; s < SETS; s++) begin
        for (int w = 0; w < WAYS; w++) begin
          line_ok[s][w] = 1'b0;
          line_age[s][w] = '0;
        end
      end
      expected_lookups.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_lookups.size() == 0) begin
          error_total++;
          $display("%0t: result word with none expected: hit=%0b way=%0d misses=%0d",
                   $time, out_hit, out_way_used, out_miss_total);
        end else begin
          want = expected_lookups.pop_front();
          if (out_hit !== want.hit) begin
            error_total++;
            $display("%0t: hit expected %0b got %0b", $time, want.hit, out_hit);
          end
          if (out_way_used !== want.way) begin
            error_total++;
            $display("%0t: way_used expected %0d got %0d", $time, want.way, out_way_used);
          end
          if (out_miss_total !== want.misses) begin
            error_total++;
            $display("%0t: miss_total expected %0d got %0d", $time, want.misses,
                     out_miss_total);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_OFFSET: offset_sel = cfg_data[OFFSET_W-1:0];
          REG_INDEX:  index_sel = cfg_data[INDEX_W-1:0];
          REG_ASSOC:  assoc_sel = cfg_data[ASSOC_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_lookups.push_back(predict_lookup(in_address));
    end
    mismatches <= error_total;
    lookups_pending <= expected_lookups.size();
  end

endmodule

[tb/set_assoc_lru_cache_tags_tb.sv]
`timescale 1ns / 100ps
// Top of the LRU tag store bench: clock, reset, address and config stimulus,
// output back-pressure and verdict. Needs salc_pkg, the block and its checker.
module set_assoc_lru_cache_tags_tb;
  import salc_pkg::*;

  localparam int MAX_INDEX      = 8;
  localparam int MAX_ASSOC      = 3;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 61;
  localparam int HOLD_PHASE     = 5;
  localparam int HOLD_CYCLES    = 300;
  localparam int STALL_LIMIT    = 4000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [ADDR_IN_W-1:0]  in_address = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_hit;
  logic [WAY_OUT_W-1:0]  out_way_used;
  logic [COUNT_W-1:0]    out_miss_total;
  int                    mismatches;
  int                    lookups_pending;

  bit sink_hold = 1'b0;
  bit steady_feed = 1'b0;
  int burst_left = 0;
  int quiet_cycles = 0;
  int cur_off = OFFSET_RST;
  int cur_ib = INDEX_RST;
  int cur_ways = 1 << ASSOC_RST;

  set_assoc_lru_cache_tags #(
    .ADDR_BITS      (ADDR_IN_W),
    .MAX_INDEX_BITS (MAX_INDEX),
    .MAX_ASSOC_BITS (MAX_ASSOC)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_address     (in_address),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit        (out_hit),
    .out_way_used   (out_way_used),
    .out_miss_total (out_miss_total)
  );

  set_assoc_lru_cache_tags_checker #(
    .MAX_INDEX_BITS (MAX_INDEX),
    .MAX_ASSOC_BITS (MAX_ASSOC)
  ) lookup_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_address      (in_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_way_used    (out_way_used),
    .out_miss_total  (out_miss_total),
    .mismatches      (mismatches),
    .lookups_pending (lookups_pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver back-pressure: random-length runs of differing stall density
  initial begin : sink_pattern
    int sink_mode;
    int sink_left;
    sink_mode = 0;
    sink_left = 0;
    forever begin
      @(posedge clk);
      if (sink_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold = 1'b0;
      end
      if (sink_left == 0) begin
        sink_mode = $urandom_range(0, 3);
        sink_left = $urandom_range(4, 60);
      end
      sink_left--;
      case (sink_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ~out_ready;
      endcase
    end
  end

  task automatic send_word(input logic [ADDR_IN_W-1:0] addr);
    in_valid <= 1'b1;
    in_address <= addr;
    do @(posedge clk); while (!in_ready);
    if (!steady_feed) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (lookups_pending != 0) @(posedge clk);
  endtask

  task automatic set_split(input logic [OFFSET_W-1:0] off, input logic [INDEX_W-1:0] idx,
                           input logic [ASSOC_W-1:0] ways, input bit stray);
    logic [CFG_IDX_W-1:0]  reg_sel [4];
    logic [CFG_DATA_W-1:0] reg_val [4];
    logic [31:0]           rnd;
    rnd = $urandom;
    reg_sel[0] = REG_OFFSET;
    reg_val[0] = off;
    reg_sel[1] = REG_INDEX;
    reg_val[1] = idx;
    reg_sel[2] = REG_ASSOC;
    reg_val[2] = {rnd[1:0], ways};
    reg_sel[3] = REG_SPARE;
    reg_val[3] = rnd[7:4];
    for (int k = 0; k < (stray ? 4 : 3); k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_sel[k];
      cfg_data <= reg_val[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_off = off;
    cur_ib = (idx > MAX_INDEX) ? MAX_INDEX : idx;
    cur_ways = 1 << ways;
  endtask

  function automatic logic [ADDR_IN_W-1:0] make_addr(input logic [31:0] tag, input int set_no);
    logic [63:0] a;
    logic [63:0] low;
    low = {$urandom, $urandom};
    a = ({32'd0, tag} << (cur_off + cur_ib)) |
        ((64'(set_no) & ((64'd1 << cur_ib) - 64'd1)) << cur_off) |
        (low & ((64'd1 << cur_off) - 64'd1));
    return a[ADDR_IN_W-1:0];
  endfunction

  // mostly a small tag pool over a few neighboring sets, so lines get reused and evicted
  task automatic random_lookups(input int count);
    logic [31:0] pool [12];
    int          pool_n;
    int          span;
    int          set_base;
    int          r;
    pool_n = cur_ways + $urandom_range(0, 3);
    span = $urandom_range(1, 4);
    set_base = $urandom;
    for (int i = 0; i < pool_n; i++) begin
      r = $urandom_range(0, 9);
      pool[i] = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : (r < 5) ? $urandom_range(0, 15)
                                                                      : $urandom;
    end
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 8)
        send_word($urandom);
      else if (r < 11)
        send_word(r[0] ? 32'hFFFF_FFFF : 32'h0);
      else
        send_word(make_addr(pool[$urandom_range(0, pool_n - 1)],
                            set_base + $urandom_range(0, span - 1)));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset split: offset 6, index 8, 8 ways; tag starts at bit 14
    send_word(32'h0000_0000);
    send_word(32'h0000_003F);
    send_word(32'hFFFF_FFFF);
    send_word(32'hFFFF_FFC0);
    for (int t = 1; t <= 8; t++) send_word(t << 14);
    send_word(32'h0000_0000);
    send_word(3 << 14);

    // single line; stored lines stay and are read under the new split
    wait_idle();
    set_split(4'd0, 4'd0, 2'd0, 1'b1);
    send_word(32'd8);
    send_word(32'd0);
    send_word(32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF);

    // oversized offset and index
    wait_idle();
    set_split(4'd15, 4'd15, 2'd3, 1'b0);
    send_word(32'hFFFF_FFFF);
    send_word(32'h007F_8000);
    send_word(32'hFFFF_FFFF);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: set_split(4'd12, 4'd8, 2'd3, 1'b1);
        1: set_split(4'd0, 4'd0, 2'd3, 1'b0);
        2: set_split(4'd15, 4'd9, 2'd0, 1'b1);
        3: set_split(4'd13, 4'd2, 2'd2, 1'b0);
        default: set_split(OFFSET_W'($urandom_range(0, 15)), INDEX_W'($urandom_range(0, 15)),
                           ASSOC_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      endcase
      steady_feed = (p % 4 == 1) || (p == HOLD_PHASE);
      if (p == HOLD_PHASE) sink_hold = 1'b1;
      random_lookups(PHASE_ITEMS);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
